@@ rtl/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg - RGB to HSV converter shared types
// Transaction payloads, divider chain data and hue constants.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int unsigned QUO_W  = 12;
	localparam int unsigned REM_W  = 20;
	localparam int unsigned DVS_W  = 19;
	localparam int unsigned CELLS  = QUO_W;

	localparam logic [14:0] HUE_OFS_GREEN = 15'd7680;
	localparam logic [14:0] HUE_OFS_BLUE  = 15'd15360;
	localparam logic [15:0] HUE_FULL      = 16'd23040;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [14:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_t;

	typedef enum logic [1:0] {
		DOM_RED   = 2'd0,
		DOM_GREEN = 2'd1,
		DOM_BLUE  = 2'd2
	} dom_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DVS_W-1:0] dvs;
		logic [QUO_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic       neg;
		dom_t       dom;
		logic       hue_zero;
		logic       sat_zero;
		logic [7:0] bright;
	} side_t;

	typedef struct packed {
		div_t  h;
		div_t  s;
		side_t sb;
	} chain_t;

	// one restoring step: compare against the aligned divisor, then realign
	function automatic div_t div_step(div_t x);
		div_t             y;
		logic [REM_W-1:0] dvs_ext;
		logic             take;
		dvs_ext = {1'b0, x.dvs};
		take    = x.rem >= dvs_ext;
		y.rem   = take ? (x.rem - dvs_ext) : x.rem;
		y.dvs   = x.dvs >> 1;
		y.quo   = {x.quo[QUO_W-2:0], take};
		return y;
	endfunction

endpackage

@@ rtl/rhc_prep.sv @@
// ----------------------------------------------------------------------------
// rhc_prep - front stage
// Max, min, dominant channel and scaled numerators for both dividers.
// ----------------------------------------------------------------------------
module rhc_prep import rhc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld,
	input  rgb_t   pixel,
	output logic   vld_s0,
	output chain_t dat_s0
);

	logic [7:0] hi, lo, delta, mag;
	logic [8:0] d;
	dom_t       dom;
	chain_t     nxt;

	always_comb begin
		hi = pixel.red;
		lo = pixel.red;
		if (pixel.green > hi) hi = pixel.green;
		if (pixel.blue > hi) hi = pixel.blue;
		if (pixel.green < lo) lo = pixel.green;
		if (pixel.blue < lo) lo = pixel.blue;
		delta = hi - lo;

		if (hi == pixel.red) begin
			dom = DOM_RED;
			d   = {1'b0, pixel.green} - {1'b0, pixel.blue};
		end else if (hi == pixel.green) begin
			dom = DOM_GREEN;
			d   = {1'b0, pixel.blue} - {1'b0, pixel.red};
		end else begin
			dom = DOM_BLUE;
			d   = {1'b0, pixel.red} - {1'b0, pixel.green};
		end
		mag = d[8] ? 8'(-d) : d[7:0];

		// 3840 = 4096 - 256, 255 = 256 - 1
		nxt.h.rem = {mag, 12'd0} - {4'd0, mag, 8'd0};
		nxt.h.dvs = {delta, 11'd0};
		nxt.h.quo = '0;
		nxt.s.rem = {4'd0, delta, 8'd0} - {12'd0, delta};
		nxt.s.dvs = {hi, 11'd0};
		nxt.s.quo = '0;
		nxt.sb.neg      = d[8];
		nxt.sb.dom      = dom;
		nxt.sb.hue_zero = (delta == 8'd0);
		nxt.sb.sat_zero = (hi == 8'd0);
		nxt.sb.bright   = hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		dat_s0 <= nxt;
	end

endmodule

@@ rtl/rhc_cell.sv @@
// ----------------------------------------------------------------------------
// rhc_cell - divider chain cell
// One quotient bit for hue and for saturation, registered to the next cell.
// ----------------------------------------------------------------------------
module rhc_cell import rhc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld_i,
	input  chain_t dat_i,
	output logic   vld_q,
	output chain_t dat_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		dat_q.h  <= div_step(dat_i.h);
		dat_q.s  <= div_step(dat_i.s);
		dat_q.sb <= dat_i.sb;
	end

endmodule

@@ rtl/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter - RGB to HSV pixel converter
// Front stage, twelve-cell divider chain and hue/saturation finish.
// ----------------------------------------------------------------------------
// Takes one pixel per clock: busy is always low, so every cycle with start
// high is a transaction. Each result appears on result with done high for
// exactly one cycle, after the front stage register, twelve divider cells
// each settling one quotient bit of both hue and saturation, and the output
// register. Results come in pixel order and cannot be held off.
module rgb_to_hsv_converter import rhc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rgb_t pixel,
	output logic done,
	output hsv_t result
);

	localparam int unsigned LATENCY = CELLS + 2;

	logic   vld [CELLS+1];
	chain_t dat [CELLS+1];

	logic [14:0] ofs;
	logic [15:0] hsum, hfix;
	hsv_t        res_nxt;

	assign busy = 1'b0;

	rhc_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start),
		.pixel  (pixel),
		.vld_s0 (vld[0]),
		.dat_s0 (dat[0])
	);

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		rhc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld[i]),
			.dat_i  (dat[i]),
			.vld_q  (vld[i+1]),
			.dat_q  (dat[i+1])
		);
	end

	always_comb begin
		case (dat[CELLS].sb.dom)
			DOM_GREEN: ofs = HUE_OFS_GREEN;
			DOM_BLUE:  ofs = HUE_OFS_BLUE;
			default:   ofs = '0;
		endcase
		if (dat[CELLS].sb.neg) begin
			hsum = {1'b0, ofs} - {4'd0, dat[CELLS].h.quo};
		end else begin
			hsum = {1'b0, ofs} + {4'd0, dat[CELLS].h.quo};
		end
		hfix = hsum[15] ? (hsum + HUE_FULL) : hsum;

		res_nxt.hue        = dat[CELLS].sb.hue_zero ? '0 : hfix[14:0];
		res_nxt.saturation = dat[CELLS].sb.sat_zero ? '0 : dat[CELLS].s.quo[7:0];
		res_nxt.brightness = dat[CELLS].sb.bright;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		result <= res_nxt;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LATENCY) done)
		else $error("result strobe missing after fixed latency");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.hue < 15'd23040)
		else $error("hue out of range");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.brightness == 8'd0 |-> result.saturation == 8'd0 && result.hue == 15'd0)
		else $error("black pixel with nonzero saturation or hue");

endmodule

@@ verif/tb_rgb_to_hsv_converter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter - self-checking bench for the RGB to HSV converter
// Corner pixels then biased random pixels under several pacing phases. Every
// accepted transaction is converted by an integer HSV model in the bench and
// compared field by field with the strobed result, in order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
	import rhc_pkg::*;

	localparam int HUE_SIXTH   = 3840;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_WAIT  = 20;

	typedef struct {
		rgb_t px;
		int   idle_pct;
		bit   drain;
	} pixel_job_t;

	logic clk;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	rgb_t pixel = '0;
	logic done;
	hsv_t result;

	logic       took;
	pixel_job_t pixel_queue[$];
	hsv_t       hsv_due[$];
	int         n_errors  = 0;
	int         n_sent    = 0;
	int         n_checked = 0;
	int         n_cycles  = 0;
	rgb_t       corners [20];

	rgb_to_hsv_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	function automatic hsv_t hsv_of(rgb_t px);
		int   r, g, b, top, bot, span, diff, base, h;
		hsv_t o;
		r   = px.red;
		g   = px.green;
		b   = px.blue;
		top = r;
		bot = r;
		if (g > top) top = g;
		if (b > top) top = b;
		if (g < bot) bot = g;
		if (b < bot) bot = b;
		span = top - bot;
		h    = 0;
		if (span != 0) begin
			if (top == r) begin
				diff = g - b;
				base = 0;
			end else if (top == g) begin
				diff = b - r;
				base = int'(HUE_OFS_GREEN);
			end else begin
				diff = r - g;
				base = int'(HUE_OFS_BLUE);
			end
			h = (HUE_SIXTH * diff) / span + base;
			if (h < 0) h += int'(HUE_FULL);
		end
		o.hue        = h[14:0];
		o.saturation = (top == 0) ? 8'd0 : 8'((255 * span) / top);
		o.brightness = top[7:0];
		return o;
	endfunction

	// mostly uniform, with greys, ties, saturated extremes and near-greys mixed in
	function automatic rgb_t pick_pixel();
		int   v, w, c, k;
		int   ch [3];
		rgb_t px;
		v = $urandom_range(255);
		w = $urandom_range(v);
		case ($urandom_range(9))
			5: ch = '{v, v, v};
			6: begin
				case ($urandom_range(2))
					0: ch = '{v, v, w};
					1: ch = '{v, w, v};
					default: ch = '{w, v, v};
				endcase
			end
			7: begin
				for (k = 0; k < 3; k++) begin
					c = $urandom_range(2);
					ch[k] = (c == 0) ? 0 : (c == 1) ? 255 : $urandom_range(255);
				end
			end
			8: begin
				ch = '{$urandom_range(255), $urandom_range(255), $urandom_range(255)};
				ch[$urandom_range(2)] = 0;
			end
			9: begin
				for (k = 0; k < 3; k++) begin
					c = v + $urandom_range(4) - 2;
					ch[k] = (c < 0) ? 0 : (c > 255) ? 255 : c;
				end
			end
			default: ch = '{$urandom_range(255), $urandom_range(255), $urandom_range(255)};
		endcase
		px.red   = ch[0][7:0];
		px.green = ch[1][7:0];
		px.blue  = ch[2][7:0];
		return px;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", n_cycles,
				hsv_due.size());
			$display("rgb_to_hsv_converter regression: fail");
			$finish;
		end
	end

	// driver: a held transaction stays up until busy drops
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (pixel_queue.size() == 0) begin
				start <= 1'b0;
			end else if (pixel_queue[0].drain && hsv_due.size() != 0) begin
				start <= 1'b0;
			end else if ($urandom_range(99) < pixel_queue[0].idle_pct) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				pixel <= pixel_queue[0].px;
				pixel_queue.pop_front();
			end
		end
	end

	// monitor: record accepted transactions, check strobed results in order
	always @(posedge clk or negedge arst_n) begin
		hsv_t want;
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (done) begin
				if (hsv_due.size() == 0) begin
					$error("result with nothing outstanding: hue %0d sat %0d val %0d",
						result.hue, result.saturation, result.brightness);
					n_errors++;
				end else begin
					want = hsv_due.pop_front();
					n_checked++;
					if (result.hue !== want.hue) begin
						$error("hue: expected %0d, got %0d", want.hue, result.hue);
						n_errors++;
					end
					if (result.saturation !== want.saturation) begin
						$error("saturation: expected %0d, got %0d", want.saturation,
							result.saturation);
						n_errors++;
					end
					if (result.brightness !== want.brightness) begin
						$error("brightness: expected %0d, got %0d", want.brightness,
							result.brightness);
						n_errors++;
					end
				end
			end
			if (start && !busy) begin
				hsv_due.push_back(hsv_of(pixel));
				n_sent++;
			end
		end
	end

	initial begin
		int         p, i;
		int         phase_len [4];
		int         phase_idle [4];
		pixel_job_t job;

		// black, white, greys, primaries, max ties, hue wrap below zero, tiny max
		corners = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
			24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
			24'hFF00FE, 24'hFF0001, 24'h0100FF, 24'hFFFEFE, 24'h010000,
			24'h000100, 24'h000001, 24'h7F80FF, 24'h80FF7F, 24'h123456};
		foreach (corners[i]) begin
			job.px       = corners[i];
			job.idle_pct = 0;
			job.drain    = 1'b0;
			pixel_queue.push_back(job);
		end

		phase_len  = '{500, 480, 460, 460};
		phase_idle = '{0, 48, 25, 0};
		for (p = 0; p < 4; p++) begin
			for (i = 0; i < phase_len[p]; i++) begin
				job.px       = pick_pixel();
				job.idle_pct = phase_idle[p];
				job.drain    = (i == 0);
				pixel_queue.push_back(job);
			end
		end

		while (pixel_queue.size() != 0 || (start && !took)) @(posedge clk);
		while (hsv_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d pixels converted across corner cases and four pacing phases;",
			n_sent);
		$display("%0d results compared, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0 && hsv_due.size() == 0) begin
			$display("rgb_to_hsv_converter regression: pass");
		end else begin
			$display("rgb_to_hsv_converter regression: fail");
		end
		$finish;
	end

endmodule
